[src/bsmv_pkg.sv]
package bsmv_pkg;

  localparam int ROWS_DEF      = 64;
  localparam int MAX_BAND_DEF  = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_OUT       = 64;

  typedef enum logic [1:0] {
    CMD_BAND  = 2'd0,
    CMD_X     = 2'd1,
    CMD_Y     = 2'd2,
    CMD_START = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    REG_LOWER_BAND = 3'd0,
    REG_UPPER_BAND = 3'd1,
    REG_START_ROW  = 3'd2,
    REG_START_DIAG = 3'd3,
    REG_NUM_ROWS   = 3'd4,
    REG_NUM_COLS   = 3'd5,
    REG_ALPHA      = 3'd6,
    REG_BETA       = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [2:0]         lower_band;
    logic [2:0]         upper_band;
    logic [5:0]         start_row;
    logic signed [3:0]  start_diag;
    logic [6:0]         num_rows;
    logic [6:0]         num_cols;
    logic signed [31:0] alpha_gain;
    logic signed [31:0] beta_gain;
  } cfg_t;

  typedef struct packed {
    logic       row_start;
    logic       col_issue;
    logic       fin;
    logic       mul;
    logic       add;
    logic       emit;
    logic       last;
    logic [6:0] r;
    logic [6:0] c;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctl_stat_t;

endpackage

[src/bsmv_ctrl.sv]
module bsmv_ctrl #(
  parameter int ROWS = bsmv_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bsmv_pkg::cfg_t     cfg,
  input  logic               in_valid,
  input  logic [1:0]         command,
  output logic               in_ready,
  input  bsmv_pkg::ctl_stat_t stat,
  output bsmv_pkg::ctl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SETUP = 8'b00000010,
    S_COLS  = 8'b00000100,
    S_DRAIN = 8'b00001000,
    S_FIN   = 8'b00010000,
    S_MUL   = 8'b00100000,
    S_ADD   = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  state_t     state, state_next;
  logic [6:0] cnt, cnt_next;
  logic [6:0] r, r_next;
  logic [6:0] c, c_next;
  logic [6:0] cols, cols_next;
  logic       dcnt, dcnt_next;

  logic [11:0] rows12, room, lim;
  logic [6:0]  cnt_calc, cols_calc;

  always_comb begin
    rows12 = 12'(ROWS);
    room = (12'(cfg.start_row) < rows12) ? rows12 - 12'(cfg.start_row) : 12'd0;
    lim = 12'(cfg.num_rows);
    if (room < lim) lim = room;
    if (lim > 12'(bsmv_pkg::MAX_OUT)) lim = 12'(bsmv_pkg::MAX_OUT);
    cnt_calc = lim[6:0];
    cols_calc = (12'(cfg.num_cols) > rows12) ? rows12[6:0] : cfg.num_cols;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    r_next = r;
    c_next = c;
    cols_next = cols;
    dcnt_next = dcnt;
    cmd = '0;
    cmd.r = r;
    cmd.c = c;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid && command == bsmv_pkg::CMD_START) state_next = S_SETUP;
      end
      S_SETUP: begin
        cnt_next = cnt_calc;
        cols_next = cols_calc;
        r_next = '0;
        c_next = '0;
        dcnt_next = 1'b0;
        if (cnt_calc == 7'd0) begin
          state_next = S_IDLE;
        end else begin
          cmd.row_start = 1'b1;
          state_next = (cols_calc != 7'd0) ? S_COLS : S_DRAIN;
        end
      end
      S_COLS: begin
        cmd.col_issue = 1'b1;
        c_next = c + 7'd1;
        if (c + 7'd1 == cols) begin
          dcnt_next = 1'b0;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        dcnt_next = 1'b1;
        if (dcnt) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (r + 7'd1 == cnt);
          if (r + 7'd1 == cnt) begin
            state_next = S_IDLE;
          end else begin
            r_next = r + 7'd1;
            c_next = '0;
            dcnt_next = 1'b0;
            cmd.row_start = 1'b1;
            state_next = (cols != 7'd0) ? S_COLS : S_DRAIN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      r <= '0;
      c <= '0;
      cols <= '0;
      dcnt <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      r <= r_next;
      c <= c_next;
      cols <= cols_next;
      dcnt <= dcnt_next;
    end
  end

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.col_issue |-> (c < cols))
    else $error("column issued past end");
  a_emit_row_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (r < cnt))
    else $error("row emitted past count");
  a_fin_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> $past(state == S_DRAIN))
    else $error("accumulator read before drain");

endmodule

[src/bsmv_datapath.sv]
module bsmv_datapath #(
  parameter int ROWS      = bsmv_pkg::ROWS_DEF,
  parameter int MAX_BAND  = bsmv_pkg::MAX_BAND_DEF,
  parameter int FRAC_BITS = bsmv_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bsmv_pkg::cfg_t      cfg,
  input  logic                ld_en,
  input  logic [1:0]          command,
  input  logic [5:0]          row_index,
  input  logic signed [3:0]   diag_offset,
  input  logic [5:0]          vec_index,
  input  logic signed [31:0]  value,
  input  bsmv_pkg::ctl_cmd_t  cmd,
  output bsmv_pkg::ctl_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          out_row,
  output logic signed [31:0]  out_value,
  output logic                saturated,
  output logic                last
);

  localparam int BW = 2 * MAX_BAND + 1;
  localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW = $clog2(ROWS * BW);
  localparam int DW = $clog2(BW);

  logic signed [31:0] band_mem [ROWS*BW];
  logic signed [31:0] x_mem [ROWS];
  logic signed [31:0] y_mem [ROWS];

  logic signed [31:0] band_q, x_q, y_q;
  logic               v1, v2;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [31:0] s_reg;
  logic               sflag;
  logic signed [63:0] ap, bp;
  logic signed [31:0] res;
  logic               rflag;

  logic signed [11:0] d, lbs, ubs, didx_w;
  logic               in_band;
  logic [15:0]        r16, c16, row16, vec16;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               band_we, x_we, y_we;
  logic signed [7:0]  lo8, dg8;
  logic signed [64:0] sum;
  logic               out_free;

  always_comb begin
    r16 = 16'(cmd.r);
    c16 = 16'(cmd.c);
    row16 = 16'(row_index);
    vec16 = 16'(vec_index);
    lbs = (12'(cfg.lower_band) > 12'(MAX_BAND)) ? 12'(MAX_BAND) : 12'(cfg.lower_band);
    ubs = (12'(cfg.upper_band) > 12'(MAX_BAND)) ? 12'(MAX_BAND) : 12'(cfg.upper_band);
    d = $signed(12'(cmd.c)) - $signed(12'(cmd.r)) + 12'(cfg.start_diag);
    in_band = (d >= -lbs) && (d <= ubs);
    didx_w = d + 12'(MAX_BAND);
    rd_addr = AW'(16'(cfg.start_row) + r16) * AW'(BW) + AW'(didx_w[DW-1:0]);
    lo8 = -8'(MAX_BAND);
    dg8 = 8'(diag_offset);
    wr_addr = AW'(row16[IW-1:0]) * AW'(BW) + AW'(dg8 + 8'(MAX_BAND));
    band_we = ld_en && command == bsmv_pkg::CMD_BAND && dg8 >= lo8
              && dg8 <= 8'(MAX_BAND) && row16 < 16'(ROWS);
    x_we = ld_en && command == bsmv_pkg::CMD_X && vec16 < 16'(ROWS);
    y_we = ld_en && command == bsmv_pkg::CMD_Y && vec16 < 16'(ROWS);
    sum = 65'(ap >>> FRAC_BITS) + 65'(bp >>> FRAC_BITS);
    out_free = !out_valid || out_ready;
    stat.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (band_we) band_mem[wr_addr] <= value;
    band_q <= band_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (x_we) x_mem[vec16[IW-1:0]] <= value;
    x_q <= x_mem[c16[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (y_we) y_mem[vec16[IW-1:0]] <= value;
    else if (cmd.emit) y_mem[r16[IW-1:0]] <= res;
    y_q <= y_mem[r16[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.col_issue && in_band;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(band_q) * 64'(x_q);
    if (cmd.row_start) acc <= '0;
    else if (v2) acc <= acc + (prod >>> FRAC_BITS);
    if (cmd.fin) begin
      if (acc > 64'sh7FFFFFFF) begin
        s_reg <= 32'sh7FFFFFFF;
        sflag <= 1'b1;
      end else if (acc < -64'sh80000000) begin
        s_reg <= 32'sh80000000;
        sflag <= 1'b1;
      end else begin
        s_reg <= acc[31:0];
        sflag <= 1'b0;
      end
    end
    if (cmd.mul) begin
      ap <= 64'(cfg.alpha_gain) * 64'(s_reg);
      bp <= 64'(cfg.beta_gain) * 64'(y_q);
    end
    if (cmd.add) begin
      if (sum > 65'sh7FFFFFFF) begin
        res <= 32'sh7FFFFFFF;
        rflag <= 1'b1;
      end else if (sum < -65'sh80000000) begin
        res <= 32'sh80000000;
        rflag <= 1'b1;
      end else begin
        res <= sum[31:0];
        rflag <= sflag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row <= cmd.r[5:0];
      out_value <= res;
      saturated <= rflag;
      last <= cmd.last;
    end
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result overwritten");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result lost");
  a_no_load_in_run: assert property (@(posedge clk) disable iff (rst)
    ld_en |-> !cmd.col_issue && !cmd.emit)
    else $error("load during compute");

endmodule

[src/banded_submatrix_vector_multiply.sv]
// Banded sub-matrix times vector, y = alpha*A*x + beta*y, signed Q16.16 with a 64-bit
// accumulator. Load items (band entry, x or y element) are taken one per cycle while idle.
// A start item walks each row over num_cols columns (at most ROWS), one column per cycle
// through the band memory read port, then waits for a free result port; no input is taken
// until the run's last result is loaded into the output register. Configuration registers
// are to be written through the cfg channel while the block is idle; it is not enforced.
module banded_submatrix_vector_multiply #(
  parameter int ROWS      = bsmv_pkg::ROWS_DEF,
  parameter int MAX_BAND  = bsmv_pkg::MAX_BAND_DEF,
  parameter int FRAC_BITS = bsmv_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [5:0]         row_index,
  input  logic signed [3:0]  diag_offset,
  input  logic [5:0]         vec_index,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_row,
  output logic signed [31:0] out_value,
  output logic               saturated,
  output logic               last
);

  bsmv_pkg::cfg_t      cfg;
  bsmv_pkg::ctl_cmd_t  cmd;
  bsmv_pkg::ctl_stat_t stat;
  logic                ld_en;

  assign cfg_ready = 1'b1;
  assign ld_en = in_valid && in_ready && command != bsmv_pkg::CMD_START;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_band <= 3'd0;
      cfg.upper_band <= 3'd0;
      cfg.start_row <= 6'd0;
      cfg.start_diag <= 4'sd0;
      cfg.num_rows <= 7'd1;
      cfg.num_cols <= 7'd1;
      cfg.alpha_gain <= 32'sd65536;
      cfg.beta_gain <= 32'sd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsmv_pkg::REG_LOWER_BAND: cfg.lower_band <= cfg_data[2:0];
        bsmv_pkg::REG_UPPER_BAND: cfg.upper_band <= cfg_data[2:0];
        bsmv_pkg::REG_START_ROW:  cfg.start_row <= cfg_data[5:0];
        bsmv_pkg::REG_START_DIAG: cfg.start_diag <= cfg_data[3:0];
        bsmv_pkg::REG_NUM_ROWS:   cfg.num_rows <= cfg_data[6:0];
        bsmv_pkg::REG_NUM_COLS:   cfg.num_cols <= cfg_data[6:0];
        bsmv_pkg::REG_ALPHA:      cfg.alpha_gain <= cfg_data;
        bsmv_pkg::REG_BETA:       cfg.beta_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  bsmv_ctrl #(.ROWS(ROWS)) u_ctrl (
    .clk(clk), .rst(rst), .cfg(cfg), .in_valid(in_valid), .command(command),
    .in_ready(in_ready), .stat(stat), .cmd(cmd)
  );

  bsmv_datapath #(.ROWS(ROWS), .MAX_BAND(MAX_BAND), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .ld_en(ld_en), .command(command),
    .row_index(row_index), .diag_offset(diag_offset), .vec_index(vec_index),
    .value(value), .cmd(cmd), .stat(stat), .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_value(out_value), .saturated(saturated), .last(last)
  );

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 2 * bsmv_pkg::MAX_BAND_DEF + 1;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int SETTLE = 20;

  typedef enum {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t             kind;
    bsmv_pkg::cmd_code_t  cmd;
    logic [5:0]           row;
    logic signed [3:0]    diag;
    logic [5:0]           vidx;
    logic [31:0]          val;
    bsmv_pkg::reg_index_t ridx;
    logic [31:0]          rdata;
    int                   idle;
    int                   stall;
  } op_t;

  typedef struct {
    logic [5:0]  row;
    logic [31:0] val;
    logic        sat;
    logic        last;
  } row_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] command = '0;
  logic [5:0] row_index = '0;
  logic signed [3:0] diag_offset = '0;
  logic [5:0] vec_index = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [5:0] out_row;
  logic signed [31:0] out_value;
  logic saturated;
  logic last;

  always #1 clk = ~clk;

  banded_submatrix_vector_multiply i_dut (.*);

  op_t         pending_ops[$];
  row_result_t expected_rows[$];
  int errors = 0;
  int cycles = 0;

  // predictor state
  logic signed [31:0] pr_band[64*NB];
  logic signed [31:0] pr_x[64];
  logic signed [31:0] pr_y[64];
  bsmv_pkg::cfg_t pr_cfg;

  // generator view, used to avoid reading unwritten entries
  bit band_wr[64][NB];
  bit x_wr[64];
  bit y_wr[64];
  int g_lb = 0, g_ub = 0, g_srow = 0, g_sdiag = 0, g_nrows = 1, g_ncols = 1;
  int g_idle = 0, g_stall = 0;
  int item_cnt = 0;

  function automatic logic signed [31:0] sat32(longint v, ref logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      flag = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  task automatic compute_rows();
    int lb, ub, cols, cnt, d, arow;
    longint acc, t;
    logic flag;
    logic signed [31:0] s, res;
    row_result_t e;
    lb = pr_cfg.lower_band > bsmv_pkg::MAX_BAND_DEF ? bsmv_pkg::MAX_BAND_DEF
                                                    : pr_cfg.lower_band;
    ub = pr_cfg.upper_band > bsmv_pkg::MAX_BAND_DEF ? bsmv_pkg::MAX_BAND_DEF
                                                    : pr_cfg.upper_band;
    cols = pr_cfg.num_cols > 64 ? 64 : pr_cfg.num_cols;
    cnt = pr_cfg.num_rows;
    if (cnt > 64 - pr_cfg.start_row) cnt = 64 - pr_cfg.start_row;
    for (int r = 0; r < cnt; r++) begin
      arow = pr_cfg.start_row + r;
      acc = 0;
      flag = 0;
      for (int c = 0; c < cols; c++) begin
        d = c - r + pr_cfg.start_diag;
        if (d >= -lb && d <= ub)
          acc += (longint'(pr_band[arow*NB + d + bsmv_pkg::MAX_BAND_DEF])
                  * longint'(pr_x[c])) >>> 16;
      end
      s = sat32(acc, flag);
      t = ((longint'(pr_cfg.alpha_gain) * longint'(s)) >>> 16)
        + ((longint'(pr_cfg.beta_gain) * longint'(pr_y[r])) >>> 16);
      res = sat32(t, flag);
      pr_y[r] = res;
      e.row = r[5:0];
      e.val = res;
      e.sat = flag;
      e.last = (r + 1 == cnt);
      expected_rows.push_back(e);
    end
  endtask

  task automatic push_item(bsmv_pkg::cmd_code_t cmd, int row, int diag, int vidx,
                           logic [31:0] val);
    op_t o;
    o.kind = OP_ITEM;
    o.cmd = cmd;
    o.row = row;
    o.diag = diag;
    o.vidx = vidx;
    o.val = val;
    o.idle = g_idle;
    o.stall = g_stall;
    pending_ops.push_back(o);
    item_cnt++;
    if (cmd == bsmv_pkg::CMD_BAND && o.diag >= -4 && o.diag <= 4)
      band_wr[o.row][o.diag + 4] = 1;
    if (cmd == bsmv_pkg::CMD_X) x_wr[o.vidx] = 1;
    if (cmd == bsmv_pkg::CMD_Y) y_wr[o.vidx] = 1;
  endtask

  task automatic push_drain();
    op_t o;
    o.kind = OP_DRAIN;
    o.idle = g_idle;
    o.stall = g_stall;
    pending_ops.push_back(o);
  endtask

  task automatic push_cfg(bsmv_pkg::reg_index_t idx, logic [31:0] data);
    op_t o;
    o.kind = OP_CFG;
    o.ridx = idx;
    o.rdata = data;
    o.idle = g_idle;
    o.stall = g_stall;
    pending_ops.push_back(o);
    case (idx)
      bsmv_pkg::REG_LOWER_BAND: g_lb = data[2:0];
      bsmv_pkg::REG_UPPER_BAND: g_ub = data[2:0];
      bsmv_pkg::REG_START_ROW:  g_srow = data[5:0];
      bsmv_pkg::REG_START_DIAG: g_sdiag = $signed(data[3:0]);
      bsmv_pkg::REG_NUM_ROWS:   g_nrows = data[6:0];
      bsmv_pkg::REG_NUM_COLS:   g_ncols = data[6:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $urandom_range(524288) - 262144;
    endcase
  endfunction

  // loads every entry the next run will read that is still unwritten, then starts
  task automatic push_start();
    int lb, ub, cols, cnt, d;
    lb = g_lb > 4 ? 4 : g_lb;
    ub = g_ub > 4 ? 4 : g_ub;
    cols = g_ncols > 64 ? 64 : g_ncols;
    cnt = g_nrows;
    if (cnt > 64 - g_srow) cnt = 64 - g_srow;
    for (int r = 0; r < cnt; r++) begin
      for (int c = 0; c < cols; c++) begin
        d = c - r + g_sdiag;
        if (d >= -lb && d <= ub) begin
          if (!band_wr[g_srow + r][d + 4])
            push_item(bsmv_pkg::CMD_BAND, g_srow + r, d, $urandom, rand_val());
          if (!x_wr[c]) push_item(bsmv_pkg::CMD_X, $urandom, $urandom, c, rand_val());
        end
      end
      if (!y_wr[r]) push_item(bsmv_pkg::CMD_Y, $urandom, $urandom, r, rand_val());
    end
    push_item(bsmv_pkg::CMD_START, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic random_cfg();
    push_drain();
    if ($urandom_range(3) == 0) push_cfg(bsmv_pkg::REG_LOWER_BAND, $urandom_range(7));
    if ($urandom_range(3) == 0) push_cfg(bsmv_pkg::REG_UPPER_BAND, $urandom_range(7));
    if ($urandom_range(2) == 0) push_cfg(bsmv_pkg::REG_START_ROW,
      $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(8));
    if ($urandom_range(2) == 0) push_cfg(bsmv_pkg::REG_START_DIAG, $urandom);
    if ($urandom_range(2) == 0) push_cfg(bsmv_pkg::REG_NUM_ROWS,
      $urandom_range(9) == 0 ? $urandom_range(127) : $urandom_range(6));
    if ($urandom_range(2) == 0) push_cfg(bsmv_pkg::REG_NUM_COLS,
      $urandom_range(9) == 0 ? 32'd64 + $urandom_range(63) : $urandom_range(1, 12));
    if ($urandom_range(2) == 0) push_cfg(bsmv_pkg::REG_ALPHA, rand_val());
    if ($urandom_range(2) == 0) push_cfg(bsmv_pkg::REG_BETA, rand_val());
  endtask

  // driver
  bit in_done = 0, cfg_done = 0, busy = 0;
  op_t cur;
  int cur_idle = 0, cur_stall = 0, drain_cnt = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (in_done || cfg_done) busy = 0;
      in_done = 0;
      cfg_done = 0;
      if (busy && cur.kind == OP_DRAIN && expected_rows.size() == 0) begin
        drain_cnt++;
        if (drain_cnt >= SETTLE) busy = 0;
      end
      if (!busy && pending_ops.size() > 0 && $urandom_range(99) >= cur_idle) begin
        cur = pending_ops.pop_front();
        cur_idle = cur.idle;
        cur_stall = cur.stall;
        busy = 1;
        drain_cnt = 0;
        if (cur.kind == OP_ITEM) begin
          command <= cur.cmd;
          row_index <= cur.row;
          diag_offset <= cur.diag;
          vec_index <= cur.vidx;
          value <= cur.val;
        end else if (cur.kind == OP_CFG) begin
          cfg_index <= cur.ridx;
          cfg_data <= cur.rdata;
        end
      end
      in_valid <= busy && cur.kind == OP_ITEM;
      cfg_valid <= busy && cur.kind == OP_CFG;
      out_ready <= $urandom_range(99) >= cur_stall;
    end
  end

  // transfer tracking, prediction and checking
  always @(posedge clk) begin
    row_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_done = 1;
        case (bsmv_pkg::reg_index_t'(cfg_index))
          bsmv_pkg::REG_LOWER_BAND: pr_cfg.lower_band = cfg_data[2:0];
          bsmv_pkg::REG_UPPER_BAND: pr_cfg.upper_band = cfg_data[2:0];
          bsmv_pkg::REG_START_ROW:  pr_cfg.start_row = cfg_data[5:0];
          bsmv_pkg::REG_START_DIAG: pr_cfg.start_diag = cfg_data[3:0];
          bsmv_pkg::REG_NUM_ROWS:   pr_cfg.num_rows = cfg_data[6:0];
          bsmv_pkg::REG_NUM_COLS:   pr_cfg.num_cols = cfg_data[6:0];
          bsmv_pkg::REG_ALPHA:      pr_cfg.alpha_gain = cfg_data;
          bsmv_pkg::REG_BETA:       pr_cfg.beta_gain = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        in_done = 1;
        case (bsmv_pkg::cmd_code_t'(command))
          bsmv_pkg::CMD_BAND:
            if (diag_offset >= -4 && diag_offset <= 4)
              pr_band[int'(row_index)*NB + int'(diag_offset) + bsmv_pkg::MAX_BAND_DEF]
                = value;
          bsmv_pkg::CMD_X: pr_x[vec_index] = value;
          bsmv_pkg::CMD_Y: pr_y[vec_index] = value;
          bsmv_pkg::CMD_START: compute_rows();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t unexpected result: row %0d value %h sat %b last %b",
                   $time, out_row, out_value, saturated, last);
          errors++;
        end else begin
          e = expected_rows.pop_front();
          if (out_row !== e.row || out_value !== e.val || saturated !== e.sat
              || last !== e.last) begin
            $display("%0t mismatch: expected row %0d value %h sat %b last %b",
                     $time, e.row, e.val, e.sat, e.last);
            $display("%0t            actual row %0d value %h sat %b last %b",
                     $time, out_row, out_value, saturated, last);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int phase;
    pr_cfg = '{lower_band: 0, upper_band: 0, start_row: 0, start_diag: 0,
               num_rows: 1, num_cols: 1, alpha_gain: 65536, beta_gain: 0};
    foreach (pr_band[i]) pr_band[i] = '0;
    foreach (pr_x[i]) begin
      pr_x[i] = '0;
      pr_y[i] = '0;
    end

    // directed: reset config, extreme values, ignored band writes
    push_item(bsmv_pkg::CMD_BAND, 0, 0, 0, 32'h7fffffff);
    push_item(bsmv_pkg::CMD_X, 0, 0, 0, 32'h7fffffff);
    push_item(bsmv_pkg::CMD_Y, 63, -4, 0, 32'h80000000);
    push_item(bsmv_pkg::CMD_BAND, 63, -8, 63, 32'h12345678);
    push_item(bsmv_pkg::CMD_BAND, 5, 7, 0, 32'h87654321);
    push_start();
    push_drain();
    push_cfg(bsmv_pkg::REG_LOWER_BAND, 7);
    push_cfg(bsmv_pkg::REG_UPPER_BAND, 7);
    push_cfg(bsmv_pkg::REG_START_ROW, 62);
    push_cfg(bsmv_pkg::REG_START_DIAG, 32'hfffffff8);
    push_cfg(bsmv_pkg::REG_NUM_ROWS, 127);
    push_cfg(bsmv_pkg::REG_NUM_COLS, 3);
    push_cfg(bsmv_pkg::REG_ALPHA, 32'h80000000);
    push_cfg(bsmv_pkg::REG_BETA, 32'h7fffffff);
    push_start();
    push_drain();
    push_cfg(bsmv_pkg::REG_START_DIAG, 7);
    push_cfg(bsmv_pkg::REG_ALPHA, 32'h7fffffff);
    push_start();
    push_drain();
    push_cfg(bsmv_pkg::REG_NUM_ROWS, 0);
    push_start();
    push_drain();
    push_cfg(bsmv_pkg::REG_LOWER_BAND, 0);
    push_cfg(bsmv_pkg::REG_UPPER_BAND, 0);
    push_cfg(bsmv_pkg::REG_START_ROW, 0);
    push_cfg(bsmv_pkg::REG_START_DIAG, 0);
    push_cfg(bsmv_pkg::REG_NUM_ROWS, 64);
    push_cfg(bsmv_pkg::REG_NUM_COLS, 1);
    push_cfg(bsmv_pkg::REG_ALPHA, 32'h00010000);
    push_cfg(bsmv_pkg::REG_BETA, 32'hffff0000);
    push_start();

    while (item_cnt < 170) begin
      phase = item_cnt * 4 / 170;
      g_idle = phase == 1 ? 49 : phase == 3 ? 13 : 0;
      g_stall = phase == 2 ? 49 : phase == 3 ? 13 : 0;
      if ($urandom_range(3) == 0) random_cfg();
      repeat ($urandom_range(4))
        push_item(bsmv_pkg::cmd_code_t'($urandom_range(2)), $urandom, $urandom, $urandom,
                  rand_val());
      push_start();
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst = 0;
    while (pending_ops.size() > 0 || busy || expected_rows.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
